/* sv/csis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csis_pkg;

   localparam int unsigned CNT_W  = 5;
   localparam int unsigned HUE_W  = 9;
   localparam int unsigned PROX_W = 8;
   localparam int unsigned MODE_W = 3;
   localparam int unsigned DRV_W  = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 9;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_THRESH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_HUE_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_HUE_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_HUE_BELOW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_HUE_ABOVE = 3'd5;

   // sorting modes, codes above 4 never trigger
   localparam logic [MODE_W-1:0] MODE_REJECT_BLUE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REJECT_RED  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STOP_ANY    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STOP_RED    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_NUDGE_BLUE  = 3'd4;

   // register reset values
   localparam logic [MODE_W-1:0] RST_MODE          = MODE_REJECT_BLUE;
   localparam logic [PROX_W-1:0] RST_NEAR_THRESH   = 8'd140;
   localparam logic [HUE_W-1:0]  RST_BLUE_HUE_LOW  = 9'd180;
   localparam logic [HUE_W-1:0]  RST_BLUE_HUE_HIGH = 9'd255;
   localparam logic [HUE_W-1:0]  RST_RED_HUE_BELOW = 9'd30;
   localparam logic [HUE_W-1:0]  RST_RED_HUE_ABOVE = 9'd350;

   // drive levels
   localparam logic signed [DRV_W-1:0] DRIVE_INTAKE  = -8'sd127;
   localparam logic signed [DRV_W-1:0] DRIVE_FORWARD = 8'sd127;
   localparam logic signed [DRV_W-1:0] DRIVE_NUDGE   = 8'sd32;
   localparam logic signed [DRV_W-1:0] DRIVE_ZERO    = 8'sd0;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_REVERSE    = 3'd1,
      PH_FORWARD    = 3'd2,
      PH_HOLD       = 3'd3,
      PH_NUDGE_STOP = 3'd4,
      PH_NUDGE_GO   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      CMD_KEEP,
      CMD_INTAKE,
      CMD_FORWARD,
      CMD_NUDGE,
      CMD_BRAKE
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [PROX_W-1:0] near_threshold;
      logic [HUE_W-1:0]  blue_hue_low;
      logic [HUE_W-1:0]  blue_hue_high;
      logic [HUE_W-1:0]  red_hue_below;
      logic [HUE_W-1:0]  red_hue_above;
   } cfg_type;

   typedef struct packed {
      logic                     run;
      phase_type                phase;
      logic [CNT_W-1:0]         count;
      logic signed [DRV_W-1:0]  drive;
      logic                     brake;
   } seq_state_type;

endpackage

`default_nettype wire

/* sv/csis_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module csis_step #(
   parameter int unsigned REVERSE_TICKS = 11,
   parameter int unsigned FORWARD_TICKS = 2,
   parameter int unsigned HOLD_TICKS    = 25,
   parameter int unsigned NUDGE_TICKS   = 10
) (
   input  csis_pkg::cfg_type                 cfg,
   input  logic [csis_pkg::PROX_W-1:0]       proximity,
   input  logic [csis_pkg::HUE_W-1:0]        hue,
   input  logic                              rearm,
   input  csis_pkg::seq_state_type           cur,
   output csis_pkg::seq_state_type           nxt
);
   import csis_pkg::*;

   // counter loads: ticks left after the first tick of a phase
   localparam logic [CNT_W-1:0] REVERSE_LOAD = CNT_W'(REVERSE_TICKS - 1);
   localparam logic [CNT_W-1:0] FORWARD_LOAD = CNT_W'(FORWARD_TICKS - 1);
   localparam logic [CNT_W-1:0] HOLD_LOAD    = CNT_W'(HOLD_TICKS - 1);
   localparam logic [CNT_W-1:0] NUDGE_LOAD   = CNT_W'(NUDGE_TICKS - 1);

   logic      run_now;
   logic      near;
   logic      blue;
   logic      red;
   cmd_type   cmd;

   assign run_now = cur.run | rearm;
   assign near    = proximity >= cfg.near_threshold;
   assign blue    = (hue > cfg.blue_hue_low) && (hue < cfg.blue_hue_high);
   assign red     = (hue < cfg.red_hue_below) || (hue > cfg.red_hue_above);

   // next phase, counter and run flag, then the command it issues
   always_comb begin
      logic intake;
      intake    = 1'b0;
      nxt.run   = run_now;
      nxt.phase = cur.phase;
      nxt.count = cur.count;
      cmd       = CMD_KEEP;

      if (cur.phase == PH_IDLE) begin
         intake = 1'b1;
      end else if (cur.count != '0) begin
         nxt.count = cur.count - 1'b1;
      end else begin
         unique case (cur.phase)
            PH_REVERSE: begin
               nxt.phase = PH_FORWARD;
               nxt.count = FORWARD_LOAD;
               cmd       = CMD_FORWARD;
            end
            PH_FORWARD: begin
               nxt.phase = PH_HOLD;
               nxt.count = HOLD_LOAD;
               cmd       = CMD_BRAKE;
            end
            PH_NUDGE_STOP: begin
               nxt.phase = PH_IDLE;
               nxt.run   = 1'b0;
               cmd       = CMD_BRAKE;
            end
            default: begin
               // hold brake or nudge done: this tick intakes
               nxt.phase = PH_IDLE;
               nxt.count = '0;
               intake    = 1'b1;
            end
         endcase
      end

      if (intake && run_now) begin
         if (((cfg.mode == MODE_REJECT_BLUE) && near && blue) ||
             ((cfg.mode == MODE_REJECT_RED) && near && red)) begin
            nxt.phase = PH_REVERSE;
            nxt.count = REVERSE_LOAD;
            cmd       = CMD_INTAKE;
         end else if ((cfg.mode == MODE_STOP_ANY) && near) begin
            nxt.run = 1'b0;
            cmd     = CMD_BRAKE;
         end else if ((cfg.mode == MODE_STOP_RED) && near && red) begin
            nxt.phase = PH_NUDGE_STOP;
            nxt.count = NUDGE_LOAD;
            cmd       = CMD_NUDGE;
         end else if ((cfg.mode == MODE_NUDGE_BLUE) && near && blue) begin
            nxt.phase = PH_NUDGE_GO;
            nxt.count = NUDGE_LOAD;
            cmd       = CMD_NUDGE;
         end else begin
            cmd = CMD_INTAKE;
         end
      end

      // command decode
      nxt.drive = cur.drive;
      nxt.brake = cur.brake;
      unique case (cmd)
         CMD_KEEP: begin
            nxt.drive = cur.drive;
            nxt.brake = cur.brake;
         end
         CMD_INTAKE: begin
            nxt.drive = DRIVE_INTAKE;
            nxt.brake = 1'b0;
         end
         CMD_FORWARD: begin
            nxt.drive = DRIVE_FORWARD;
            nxt.brake = 1'b0;
         end
         CMD_NUDGE: begin
            nxt.drive = DRIVE_NUDGE;
            nxt.brake = 1'b0;
         end
         CMD_BRAKE: begin
            nxt.drive = DRIVE_ZERO;
            nxt.brake = 1'b1;
         end
         default: begin
            nxt.drive = cur.drive;
            nxt.brake = cur.brake;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/color_sort_intake_sequencer_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// colour sort intake sequencer: each req beat is one 10 ms sensor tick
// (proximity, hue, rearm) and gives exactly one rsp beat carrying the motor
// command for that tick, the run flag and whether a timed reject or nudge
// sequence is still going. a beat passes through an input register, then the
// sequencer update, then a result register, and one beat is taken every
// cycle while rsp is not stalled; the rate is set by the state update, which
// runs once for each beat. the input register can take a new req beat while a
// finished result still waits in the result register, if it is itself empty.
// csr writes are to be made only while the block is idle; the block itself
// does not enforce this. the REVERSE, FORWARD, HOLD and NUDGE tick counts are
// parameters in the range 1 to 32.

module color_sort_intake_sequencer_top #(
   parameter int unsigned REVERSE_TICKS = 11,
   parameter int unsigned FORWARD_TICKS = 2,
   parameter int unsigned HOLD_TICKS    = 25,
   parameter int unsigned NUDGE_TICKS   = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // csr write port
   input  logic                                   csr_wr_en,
   input  logic [csis_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [csis_pkg::CSR_DATA_W-1:0]        csr_wr_data,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [csis_pkg::PROX_W-1:0]            req_proximity,
   input  logic [csis_pkg::HUE_W-1:0]             req_hue,
   input  logic                                   req_rearm,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [csis_pkg::DRV_W-1:0]      rsp_motor_drive,
   output logic                                   rsp_brake_on,
   output logic                                   rsp_running,
   output logic                                   rsp_busy_res
);
   import csis_pkg::*;

   // configuration registers
   cfg_type                cfg_ff;

   // input register
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [PROX_W-1:0]      in_prox_ff;
   logic [HUE_W-1:0]       in_hue_ff;
   logic                   in_rearm_ff;

   // sequencer state
   seq_state_type          state_ff;
   seq_state_type          state_in;

   // result register
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic signed [DRV_W-1:0] out_drive_ff;
   logic                   out_brake_ff;
   logic                   out_run_ff;
   logic                   out_busy_ff;

   logic                   req_take;
   logic                   advance;
   logic                   fire;

   // ---- csr writes, indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= RST_MODE;
         cfg_ff.near_threshold <= RST_NEAR_THRESH;
         cfg_ff.blue_hue_low   <= RST_BLUE_HUE_LOW;
         cfg_ff.blue_hue_high  <= RST_BLUE_HUE_HIGH;
         cfg_ff.red_hue_below  <= RST_RED_HUE_BELOW;
         cfg_ff.red_hue_above  <= RST_RED_HUE_ABOVE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:          cfg_ff.mode           <= csr_wr_data[MODE_W-1:0];
            CSR_NEAR_THRESH:   cfg_ff.near_threshold <= csr_wr_data[PROX_W-1:0];
            CSR_BLUE_HUE_LOW:  cfg_ff.blue_hue_low   <= csr_wr_data[HUE_W-1:0];
            CSR_BLUE_HUE_HIGH: cfg_ff.blue_hue_high  <= csr_wr_data[HUE_W-1:0];
            CSR_RED_HUE_BELOW: cfg_ff.red_hue_below  <= csr_wr_data[HUE_W-1:0];
            CSR_RED_HUE_ABOVE: cfg_ff.red_hue_above  <= csr_wr_data[HUE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---- flow control
   // the result register frees when empty or being taken this cycle
   assign advance   = !out_valid_ff || !rsp_stall;
   // the held beat moves into the result register and updates the state
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   // ---- input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_prox_ff  <= req_proximity;
         in_hue_ff   <= req_hue;
         in_rearm_ff <= req_rearm;
      end
   end

   // ---- one tick of the sequencer
   csis_step #(
      .REVERSE_TICKS (REVERSE_TICKS),
      .FORWARD_TICKS (FORWARD_TICKS),
      .HOLD_TICKS    (HOLD_TICKS),
      .NUDGE_TICKS   (NUDGE_TICKS)
   ) u_step (
      .cfg       (cfg_ff),
      .proximity (in_prox_ff),
      .hue       (in_hue_ff),
      .rearm     (in_rearm_ff),
      .cur       (state_ff),
      .nxt       (state_in)
   );

   // running with no command held and no sequence after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.run   <= 1'b1;
         state_ff.phase <= PH_IDLE;
         state_ff.count <= '0;
         state_ff.drive <= DRIVE_ZERO;
         state_ff.brake <= 1'b0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // ---- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_drive_ff <= state_in.drive;
         out_brake_ff <= state_in.brake;
         out_run_ff   <= state_in.run;
         out_busy_ff  <= (state_in.phase != PH_IDLE);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_motor_drive = out_drive_ff;
   assign rsp_brake_on    = out_brake_ff;
   assign rsp_running     = out_run_ff;
   assign rsp_busy_res    = out_busy_ff;

   // ---- checks

   // a braking command never carries drive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_brake_on |-> rsp_motor_drive == DRIVE_ZERO)
      else $error("brake beat with nonzero drive");

   // a timed sequence only starts while running and nothing stops it midway
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase != PH_IDLE |-> state_ff.run)
      else $error("sequence in progress while stopped");

   // the tick counter is spent whenever the intake is idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_IDLE |-> state_ff.count == '0)
      else $error("tick counter left over in idle phase");

   // a result waiting under stall is neither dropped nor replaced
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && !$past(fire))
      else $error("stalled result overwritten");

endmodule

`default_nettype wire
